### hw/rtl/cfb_pkg.sv
package cfb_pkg;

    localparam logic [7:0]  START_BYTE          = 8'h7e;
    localparam logic [7:0]  END_BYTE            = 8'hfe;
    localparam logic [31:0] HEADER_OVERHEAD     = 32'd13;
    localparam int unsigned MAX_PAYLOAD_DEFAULT = 1024;

    // longest run of words one item can cause: header, check, end
    localparam int unsigned RUN_DEPTH = 13;
    localparam int unsigned RUN_IDX_W = $clog2(RUN_DEPTH);
    localparam int unsigned HDR_WORDS = 11;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_PAYLOAD = 1'b1
    } req_type_t;

    typedef logic [7:0] byte_t;

    // 3 * x modulo 256
    function automatic byte_t triple(input byte_t x);
        triple = x + {x[6:0], 1'b0};
    endfunction

    // floor(x / 11) for 8-bit x through a reciprocal, exact over 0..255
    function automatic byte_t div11(input byte_t x);
        logic [16:0] prod;
        prod  = 17'(x) * 17'd373;
        div11 = {3'd0, prod[16:12]};
    endfunction

endpackage

### hw/rtl/command_frame_builder.sv
// channel   dir  tdata                                        tuser                     tlast
// s_        in   command_code[15:0] payload_len[26:16]        req_type[0]               -
//                payload_byte[34:27] zero[39:35]
// m_        out  out_byte[7:0]                                frame_end[0] seq_error[1] run_last
//
// payload words are taken one per cycle while the output side keeps pace; a start word
// causes a run of 11 or 13 output words, a payload word 1 or 3, an error word 1.
// the run register drains into the output register one word per cycle while m_tready
// allows; the next input word is taken in the cycle the last word of the run moves out.
// aresetn is synchronous, active low, and closes any open frame.
// a stall on m_tready holds the output register and, while a run is pending, s_tready.
module command_frame_builder #(
    parameter int unsigned MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command_code[15:0], payload_len[26:16], payload_byte[34:27], zeros above
    input  logic [cfb_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type[0]
    input  logic [0:0]                      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_byte[7:0]
    output logic [cfb_pkg::OUT_DATA_W-1:0]  m_tdata,
    // frame_end[0], seq_error[1]
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);
    localparam logic [cfb_pkg::RUN_IDX_W-1:0] CNT_HDR =
        cfb_pkg::RUN_IDX_W'(cfb_pkg::HDR_WORDS);
    localparam logic [cfb_pkg::RUN_IDX_W-1:0] CNT_FULL =
        cfb_pkg::RUN_IDX_W'(cfb_pkg::RUN_DEPTH);

    // frame state
    logic        frame_open_reg, frame_open_next;
    logic [10:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  check_accum_reg, check_accum_next;
    logic        odd_weight_reg, odd_weight_next;

    // run register
    logic                            run_valid_reg, run_valid_next;
    cfb_pkg::byte_t                  run_bytes_reg [cfb_pkg::RUN_DEPTH];
    cfb_pkg::byte_t                  run_bytes_next [cfb_pkg::RUN_DEPTH];
    logic [cfb_pkg::RUN_IDX_W-1:0]   run_cnt_reg, run_cnt_next;
    logic [cfb_pkg::RUN_IDX_W-1:0]   run_idx_reg, run_idx_next;
    logic                            run_err_reg, run_err_next;
    logic                            run_trl_reg, run_trl_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    cfb_pkg::byte_t                  out_byte_reg, out_byte_next;
    logic                            out_fend_reg, out_fend_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_err_reg, out_err_next;

    cfb_pkg::req_type_t req;
    logic [15:0]        cmd;
    logic [10:0]        len;
    cfb_pkg::byte_t     pb;
    logic [31:0]        flen;
    logic [31:0]        len32;
    cfb_pkg::byte_t     hdr [cfb_pkg::HDR_WORDS];
    cfb_pkg::byte_t     odd_sum, even_sum, hdr_sum, pay_sum, pay_term;
    logic [10:0]        left_dec;

    logic in_accept, move, run_at_last;

    assign req   = cfb_pkg::req_type_t'(s_tuser[0]);
    assign cmd   = s_tdata[15:0];
    assign len   = s_tdata[26:16];
    assign pb    = s_tdata[34:27];
    assign len32 = {21'd0, len};
    assign flen  = len32 + cfb_pkg::HEADER_OVERHEAD;

    assign run_at_last = (run_idx_reg == run_cnt_reg - 1'b1);
    assign move        = run_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !run_valid_reg || (move && run_at_last);
    assign in_accept   = s_tvalid && s_tready;

    always_comb begin
        hdr[0]  = cfb_pkg::START_BYTE;
        hdr[1]  = cmd[15:8];
        hdr[2]  = cmd[7:0];
        hdr[3]  = flen[31:24];
        hdr[4]  = flen[23:16];
        hdr[5]  = flen[15:8];
        hdr[6]  = flen[7:0];
        hdr[7]  = len32[31:24];
        hdr[8]  = len32[23:16];
        hdr[9]  = len32[15:8];
        hdr[10] = len32[7:0];
        // positions 1..10: odd ones weigh 1, even ones 3
        odd_sum  = hdr[1] + hdr[3] + hdr[5] + hdr[7] + hdr[9];
        even_sum = hdr[2] + hdr[4] + hdr[6] + hdr[8] + hdr[10];
        hdr_sum  = odd_sum + cfb_pkg::triple(even_sum);
        pay_term = odd_weight_reg ? pb : cfb_pkg::triple(pb);
        pay_sum  = check_accum_reg + pay_term;
        left_dec = bytes_left_reg - 11'd1;
    end

    // next run and frame state for an accepted word
    always_comb begin
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        check_accum_next = check_accum_reg;
        odd_weight_next  = odd_weight_reg;
        for (int i = 0; i < cfb_pkg::RUN_DEPTH; i++) begin
            run_bytes_next[i] = run_bytes_reg[i];
        end
        run_cnt_next = run_cnt_reg;
        run_err_next = run_err_reg;
        run_trl_next = run_trl_reg;

        if (in_accept) begin
            run_err_next      = 1'b0;
            run_trl_next      = 1'b0;
            run_cnt_next      = cfb_pkg::RUN_IDX_W'(1);
            run_bytes_next[0] = '0;
            unique case (req)
                cfb_pkg::REQ_START: begin
                    if (frame_open_reg || {5'd0, len} > MAX_LEN) begin
                        run_err_next = 1'b1;
                    end else begin
                        for (int i = 0; i < cfb_pkg::HDR_WORDS; i++) begin
                            run_bytes_next[i] = hdr[i];
                        end
                        if (len == 11'd0) begin
                            run_bytes_next[cfb_pkg::HDR_WORDS]     = cfb_pkg::div11(hdr_sum);
                            run_bytes_next[cfb_pkg::HDR_WORDS + 1] = cfb_pkg::END_BYTE;
                            run_cnt_next     = CNT_FULL;
                            run_trl_next     = 1'b1;
                            check_accum_next = '0;
                            odd_weight_next  = 1'b1;
                        end else begin
                            run_cnt_next     = CNT_HDR;
                            frame_open_next  = 1'b1;
                            bytes_left_next  = len;
                            check_accum_next = hdr_sum;
                            // ten summed words leave the weight back on odd
                            odd_weight_next  = 1'b1;
                        end
                    end
                end
                cfb_pkg::REQ_PAYLOAD: begin
                    if (!frame_open_reg) begin
                        run_err_next = 1'b1;
                    end else begin
                        run_bytes_next[0] = pb;
                        if (left_dec == 11'd0) begin
                            run_bytes_next[1] = cfb_pkg::div11(pay_sum);
                            run_bytes_next[2] = cfb_pkg::END_BYTE;
                            run_cnt_next      = cfb_pkg::RUN_IDX_W'(3);
                            run_trl_next      = 1'b1;
                            frame_open_next   = 1'b0;
                            bytes_left_next   = '0;
                            check_accum_next  = '0;
                            odd_weight_next   = 1'b1;
                        end else begin
                            bytes_left_next  = left_dec;
                            check_accum_next = pay_sum;
                            odd_weight_next  = !odd_weight_reg;
                        end
                    end
                end
                default: run_err_next = 1'b1;
            endcase
        end
    end

    // run index and output register
    always_comb begin
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_fend_next  = out_fend_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (move) begin
            out_valid_next = 1'b1;
            out_byte_next  = run_bytes_reg[run_idx_reg];
            out_last_next  = run_at_last;
            out_fend_next  = run_at_last && run_trl_reg;
            out_err_next   = run_err_reg;
            run_idx_next   = run_idx_reg + 1'b1;
            if (run_at_last) begin
                run_valid_next = 1'b0;
            end
        end
        if (in_accept) begin
            run_valid_next = 1'b1;
            run_idx_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= '0;
            check_accum_reg <= '0;
            odd_weight_reg  <= 1'b1;
            run_valid_reg   <= 1'b0;
            run_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            check_accum_reg <= check_accum_next;
            odd_weight_reg  <= odd_weight_next;
            run_valid_reg   <= run_valid_next;
            run_idx_reg     <= run_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < cfb_pkg::RUN_DEPTH; i++) begin
            run_bytes_reg[i] <= run_bytes_next[i];
        end
        run_cnt_reg  <= run_cnt_next;
        run_err_reg  <= run_err_next;
        run_trl_reg  <= run_trl_next;
        out_byte_reg <= out_byte_next;
        out_fend_reg <= out_fend_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_err_reg, out_fend_reg};
    assign m_tlast  = out_last_reg;

endmodule

### sim/frame_byte_checker.sv
module frame_byte_checker
    import cfb_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // command_code[15:0], payload_len[26:16], payload_byte[34:27], zeros above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // out_byte[7:0]
    input  logic [OUT_DATA_W-1:0] m_tdata,
    // frame_end[0], seq_error[1]
    input  logic [1:0]            m_tuser,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    words_pending
);

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_end;
        logic       run_last;
        logic       seq_error;
    } frame_word_t;

    frame_word_t expected_words[$];

    // words caused by one input word, longest run is a zero-length frame
    frame_word_t run_buf [0:RUN_DEPTH-1];
    int          run_len;

    logic        frame_open;
    logic [10:0] bytes_left;
    logic [7:0]  check_sum;
    logic        odd_next;
    int          errors;

    task automatic add_word(input logic [7:0] b, input logic fend, input logic err);
        run_buf[run_len] = '{wire_byte: b, frame_end: fend, run_last: 1'b0, seq_error: err};
        run_len++;
    endtask

    task automatic add_summed(input logic [7:0] b);
        check_sum = check_sum + (odd_next ? 8'd1 : 8'd3) * b;
        odd_next  = !odd_next;
        add_word(b, 1'b0, 1'b0);
    endtask

    task automatic add_trailer();
        add_word(check_sum / 8'd11, 1'b0, 1'b0);
        add_word(END_BYTE, 1'b1, 1'b0);
        frame_open = 1'b0;
        bytes_left = '0;
        check_sum  = '0;
        odd_next   = 1'b1;
    endtask

    task automatic predict_frame_bytes(input req_type_t req, input logic [15:0] cmd,
                                       input logic [10:0] len, input logic [7:0] pb);
        logic [31:0] total_len;
        logic [31:0] len_word;
        int          i;
        run_len = 0;
        if (req == REQ_START) begin
            if (frame_open || len > MAX_PAYLOAD) begin
                add_word(8'h00, 1'b0, 1'b1);
            end else begin
                check_sum = '0;
                odd_next  = 1'b1;
                add_word(START_BYTE, 1'b0, 1'b0);
                add_summed(cmd[15:8]);
                add_summed(cmd[7:0]);
                len_word  = 32'(len);
                total_len = len_word + HEADER_OVERHEAD;
                for (i = 3; i >= 0; i--) add_summed(total_len[8*i +: 8]);
                for (i = 3; i >= 0; i--) add_summed(len_word[8*i +: 8]);
                if (len == 0) begin
                    add_trailer();
                end else begin
                    frame_open = 1'b1;
                    bytes_left = len;
                end
            end
        end else if (!frame_open) begin
            add_word(8'h00, 1'b0, 1'b1);
        end else begin
            add_summed(pb);
            bytes_left = bytes_left - 11'd1;
            if (bytes_left == 0) add_trailer();
        end
        run_buf[run_len-1].run_last = 1'b1;
        for (i = 0; i < run_len; i++) expected_words.push_back(run_buf[i]);
    endtask

    always @(posedge aclk) begin
        frame_word_t got;
        frame_word_t want;
        if (!aresetn) begin
            frame_open = 1'b0;
            bytes_left = '0;
            check_sum  = '0;
            odd_next   = 1'b1;
            errors     = 0;
            expected_words.delete();
        end else begin
            // expectations first: a word leaving now always comes from an earlier input
            if (s_tvalid && s_tready) begin
                predict_frame_bytes(req_type_t'(s_tuser[0]), s_tdata[15:0],
                                    s_tdata[26:16], s_tdata[34:27]);
            end
            if (m_tvalid && m_tready) begin
                got = '{wire_byte: m_tdata, frame_end: m_tuser[0], run_last: m_tlast,
                        seq_error: m_tuser[1]};
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got byte %02h end %0b last %0b err %0b",
                             $time, got.wire_byte, got.frame_end, got.run_last, got.seq_error);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: expected byte %02h end %0b last %0b err %0b, got byte %02h end %0b last %0b err %0b",
                                 $time, want.wire_byte, want.frame_end, want.run_last,
                                 want.seq_error, got.wire_byte, got.frame_end, got.run_last,
                                 got.seq_error);
                    end
                end
            end
        end
        fail_count    <= errors;
        words_pending <= expected_words.size();
    end

endmodule

### sim/testbench.sv
module testbench;
    import cfb_pkg::*;

    localparam int unsigned MAX_LEN = MAX_PAYLOAD_DEFAULT;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    int   fail_count;
    int   words_pending;
    int   words_offered = 0;
    int   ready_hold    = 0;
    logic gaps_on       = 1'b0;
    logic long_hold_go  = 1'b0;
    logic long_hold_done = 1'b0;

    command_frame_builder #(.MAX_PAYLOAD(MAX_LEN)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    frame_byte_checker #(.MAX_PAYLOAD(MAX_LEN)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(64'd8 * 64'd2_000_000);
        $display("command_frame_builder verification failed");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off to back up the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (long_hold_go && !long_hold_done) begin
            long_hold_done <= 1'b1;
            ready_hold     <= 399;
            m_tready       <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(0, 13);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(input req_type_t req, input logic [15:0] cmd,
                             input logic [10:0] len, input logic [7:0] pb);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, pb, len, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_offered++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
    endtask

    task automatic send_frame(input logic [15:0] cmd, input logic [10:0] len);
        int n;
        send_word(REQ_START, cmd, len, 8'($urandom));
        for (n = 0; n < len; n++) begin
            // stray start inside an open frame, the frame must carry on untouched
            if ($urandom_range(0, 29) == 0)
                send_word(REQ_START, 16'($urandom), 11'($urandom), 8'($urandom));
            send_word(REQ_PAYLOAD, 16'($urandom), 11'($urandom), 8'($urandom));
        end
    endtask

    task automatic send_random_frame();
        int          pick;
        int          size_pick;
        logic [10:0] len;
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 199);
        if (pick < 6) begin
            send_word(REQ_PAYLOAD, 16'($urandom), 11'($urandom), 8'($urandom));
        end else if (pick < 11) begin
            send_word(REQ_START, 16'($urandom), 11'($urandom_range(MAX_LEN + 1, 2047)),
                      8'($urandom));
        end else begin
            if (size_pick < 130)      len = 11'($urandom_range(0, 6));
            else if (size_pick < 180) len = 11'($urandom_range(7, 40));
            else if (size_pick < 198) len = 11'($urandom_range(41, 90));
            else                      len = 11'($urandom_range(128, 400));
            send_frame(16'($urandom), len);
        end
    endtask

    initial begin
        int stop_at;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // payload with nothing open, empty frames at the command extremes
        send_word(REQ_PAYLOAD, 16'hffff, 11'h7ff, 8'hff);
        send_word(REQ_START, 16'hffff, 11'd0, 8'hff);
        send_word(REQ_START, 16'h0000, 11'd0, 8'h00);
        // lengths past the limit
        send_word(REQ_START, 16'h1234, 11'(MAX_LEN + 1), 8'h00);
        send_word(REQ_START, 16'hffff, 11'h7ff, 8'h00);
        // start while a frame is open, then finish it
        send_word(REQ_START, 16'h1234, 11'd2, 8'h00);
        send_word(REQ_START, 16'h4321, 11'd0, 8'h00);
        send_word(REQ_PAYLOAD, 16'h0000, 11'd0, 8'h00);
        send_word(REQ_PAYLOAD, 16'hffff, 11'h7ff, 8'hff);
        send_word(REQ_START, 16'habcd, 11'd1, 8'h00);
        send_word(REQ_PAYLOAD, 16'h0000, 11'd0, 8'h80);
        send_word(REQ_START, 16'h8001, 11'd3, 8'h00);
        send_word(REQ_PAYLOAD, 16'h0000, 11'd0, 8'h7f);
        send_word(REQ_PAYLOAD, 16'h0000, 11'd0, 8'h01);
        send_word(REQ_PAYLOAD, 16'h0000, 11'd0, 8'hfe);
        send_word(REQ_PAYLOAD, 16'h5555, 11'h2aa, 8'h55);
        wait_for_drain();

        gaps_on <= 1'b1;
        stop_at = words_offered + 110;
        while (words_offered < stop_at) send_random_frame();

        long_hold_go <= 1'b1;
        stop_at = words_offered + 100;
        while (words_offered < stop_at) send_random_frame();
        wait_for_drain();

        stop_at = words_offered + 60;
        while (words_offered < stop_at) send_random_frame();

        gaps_on <= 1'b0;
        stop_at = words_offered + 50;
        while (words_offered < stop_at) send_random_frame();

        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (words_pending != 0)
            $display("%0t: %0d expected words never arrived", $time, words_pending);
        if (fail_count == 0 && words_pending == 0) begin
            $display("command_frame_builder verification clean");
        end else begin
            $display("command_frame_builder verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cfb_pkg.sv
hw/rtl/command_frame_builder.sv
sim/frame_byte_checker.sv
sim/testbench.sv
